// ===== rtl/misd_pkg.sv =====
// ----------------------------------------------------------------------------
// misd_pkg
// Shared types, register indexes and reset values for the sampled debouncer.
// ----------------------------------------------------------------------------
package misd_pkg;

   // Channels built into the block (upper bound of the CHANNELS parameter)
   localparam int NUM_CH     = 3;
   localparam int CNT_W      = 8;
   localparam int CSR_IDX_W  = 3;

   // Channel status codes
   typedef enum logic [1:0] {
      STATUS_UNKNOWN = 2'd0,
      STATUS_OFF     = 2'd1,
      STATUS_ON      = 2'd2
   } status_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_DELAY    = 3'd0,
      CSR_SAMPLE_PER_CH0 = 3'd1,
      CSR_SAMPLE_PER_CH1 = 3'd2,
      CSR_SAMPLE_PER_CH2 = 3'd3,
      CSR_CONFIRM_CH0    = 3'd4,
      CSR_CONFIRM_CH1    = 3'd5,
      CSR_CONFIRM_CH2    = 3'd6
   } csr_index_type;

   // Reset values of the configuration registers
   localparam logic [CNT_W-1:0] START_DELAY_RST = 8'd20;
   localparam logic [CNT_W-1:0] SAMPLE_PER_RST [NUM_CH] = '{8'd20, 8'd20, 8'd5};
   localparam logic [CNT_W-1:0] CONFIRM_RST    [NUM_CH] = '{8'd3, 8'd3, 8'd2};

   // Per-channel configuration handed to a channel
   typedef struct packed {
      logic [CNT_W-1:0] start_delay;
      logic [CNT_W-1:0] sample_period;
      logic [CNT_W-1:0] confirm_count;
   } ch_cfg_type;

   // Per-channel control from the top level
   typedef struct packed {
      logic advance;   // item accepted this cycle
      logic reinit;    // restart the channel before its step
   } ch_ctrl_type;

endpackage

// ===== rtl/misd_channel.sv =====
// ----------------------------------------------------------------------------
// misd_channel
// One debounce channel: start delay, sample period and confirm counting.
// ----------------------------------------------------------------------------
module misd_channel
   import misd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  ch_cfg_type  cfg,
   input  ch_ctrl_type ctrl,
   input  logic        level,
   output status_type  status_in
);

   logic [CNT_W-1:0] start_count_ff,  start_count_in;
   logic             polling_ff,      polling_in;
   logic [CNT_W-1:0] period_count_ff, period_count_in;
   logic [CNT_W-1:0] same_count_ff,   same_count_in;
   logic             last_level_ff,   last_level_in;
   logic             last_valid_ff,   last_valid_in;
   status_type       status_ff;

   // Values the step starts from, after an optional restart
   logic [CNT_W-1:0] b_start, b_period, b_same;
   logic             b_polling, b_last, b_valid, match;
   status_type       b_status;
   logic [CNT_W-1:0] same_next;

   always_comb begin
      if (ctrl.reinit) begin
         b_start   = cfg.start_delay;
         b_polling = 1'b0;
         b_period  = CNT_W'(1);
         b_same    = CNT_W'(1);
         b_last    = 1'b0;
         b_valid   = 1'b0;
         b_status  = STATUS_UNKNOWN;
      end else begin
         b_start   = start_count_ff;
         b_polling = polling_ff;
         b_period  = period_count_ff;
         b_same    = same_count_ff;
         b_last    = last_level_ff;
         b_valid   = last_valid_ff;
         b_status  = status_ff;
      end

      // Sample evaluation: count equal samples, saturating at confirm count
      match = b_valid && (level == b_last);
      if (match) begin
         same_next = (b_same < cfg.confirm_count) ? b_same + CNT_W'(1) : b_same;
      end else begin
         same_next = CNT_W'(1);
      end

      start_count_in  = b_start;
      polling_in      = b_polling;
      period_count_in = b_period;
      same_count_in   = b_same;
      last_level_in   = b_last;
      last_valid_in   = b_valid;
      status_in       = b_status;

      // Advance one tick: wait out the start delay, then poll
      if (b_polling) begin
         if (b_period[CNT_W-1:1] == '0) begin
            same_count_in   = same_next;
            last_level_in   = level;
            last_valid_in   = 1'b1;
            period_count_in = cfg.sample_period;
            if (same_next >= cfg.confirm_count) begin
               status_in = level ? STATUS_ON : STATUS_OFF;
            end
         end else begin
            period_count_in = b_period - CNT_W'(1);
         end
      end else begin
         if (b_start[CNT_W-1:1] == '0) begin
            polling_in = 1'b1;
         end else begin
            start_count_in = b_start - CNT_W'(1);
         end
      end
   end

   // Update state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         start_count_ff  <= START_DELAY_RST;
         polling_ff      <= 1'b0;
         period_count_ff <= CNT_W'(1);
         same_count_ff   <= CNT_W'(1);
         last_level_ff   <= 1'b0;
         last_valid_ff   <= 1'b0;
         status_ff       <= STATUS_UNKNOWN;
      end else if (ctrl.advance) begin
         start_count_ff  <= start_count_in;
         polling_ff      <= polling_in;
         period_count_ff <= period_count_in;
         same_count_ff   <= same_count_in;
         last_level_ff   <= last_level_in;
         last_valid_ff   <= last_valid_in;
         status_ff       <= status_in;
      end
   end

endmodule

// ===== rtl/multi_input_sampled_debouncer.sv =====
// ----------------------------------------------------------------------------
// multi_input_sampled_debouncer
// Three-channel counter-based input debouncer driven by one item per tick.
// ----------------------------------------------------------------------------
// Each item is one main tick carrying three pin levels and a peripheral-power
// flag; each item yields exactly one result item with the three channel
// statuses (0 unknown, 1 off, 2 on). The block takes one item per cycle
// while the skid entry is empty: the channel counters update in a single
// pass of short logic when the item is accepted, and the status lands in a
// result register backed by a one-entry skid stage, so a new item is taken
// even while one result waits. Configuration must be written through csr_*
// only while idle; the block itself does not enforce this. A new start delay
// reaches only channel 0, when it is restarted by low peripheral power.
module multi_input_sampled_debouncer
   import misd_pkg::*;
#(
   parameter int CHANNELS = NUM_CH
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_level_ch0,
   input  logic                 req_level_ch1,
   input  logic                 req_level_ch2,
   input  logic                 req_periph_power_on,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status_ch0,
   output logic [1:0]           rsp_status_ch1,
   output logic [1:0]           rsp_status_ch2,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata
);

   logic [CNT_W-1:0] start_delay_ff;
   logic [CNT_W-1:0] sample_period_ff [NUM_CH];
   logic [CNT_W-1:0] confirm_count_ff [NUM_CH];

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         start_delay_ff <= START_DELAY_RST;
         for (int i = 0; i < NUM_CH; i++) begin
            sample_period_ff[i] <= SAMPLE_PER_RST[i];
            confirm_count_ff[i] <= CONFIRM_RST[i];
         end
      end else if (csr_write) begin
         case (csr_index)
            CSR_START_DELAY:    start_delay_ff      <= csr_wdata;
            CSR_SAMPLE_PER_CH0: sample_period_ff[0] <= csr_wdata;
            CSR_SAMPLE_PER_CH1: sample_period_ff[1] <= csr_wdata;
            CSR_SAMPLE_PER_CH2: sample_period_ff[2] <= csr_wdata;
            CSR_CONFIRM_CH0:    confirm_count_ff[0] <= csr_wdata;
            CSR_CONFIRM_CH1:    confirm_count_ff[1] <= csr_wdata;
            CSR_CONFIRM_CH2:    confirm_count_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic       accept;
   logic       levels [NUM_CH];
   status_type status_in [NUM_CH];

   assign accept    = req_valid && req_ready;
   assign levels[0] = req_level_ch0;
   assign levels[1] = req_level_ch1;
   assign levels[2] = req_level_ch2;

   // Build the configured channels; the rest report unknown
   for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
      if (c < CHANNELS) begin : g_on
         ch_cfg_type  cfg;
         ch_ctrl_type ctrl;

         assign cfg.start_delay   = start_delay_ff;
         assign cfg.sample_period = sample_period_ff[c];
         assign cfg.confirm_count = confirm_count_ff[c];
         assign ctrl.advance      = accept;
         assign ctrl.reinit       = (c == 0) ? !req_periph_power_on : 1'b0;

         misd_channel u_channel (
            .clock     (clock),
            .reset     (reset),
            .cfg       (cfg),
            .ctrl      (ctrl),
            .level     (levels[c]),
            .status_in (status_in[c])
         );
      end else begin : g_off
         assign status_in[c] = STATUS_UNKNOWN;
      end
   end

   // Result register plus skid entry
   logic       out_valid_ff, skid_valid_ff;
   status_type out_data_ff  [NUM_CH];
   status_type skid_data_ff [NUM_CH];
   logic       drain;

   assign req_ready = !skid_valid_ff;
   assign drain     = out_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            // refill the result register from the skid entry
            if (drain) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept) begin
            if (!out_valid_ff || drain) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (drain) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload moves without reset
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (drain) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (accept) begin
         if (!out_valid_ff || drain) begin
            out_data_ff <= status_in;
         end else begin
            skid_data_ff <= status_in;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status_ch0 = out_data_ff[0];
   assign rsp_status_ch1 = out_data_ff[1];
   assign rsp_status_ch2 = out_data_ff[2];

endmodule
